[design/i2cseq_pkg.sv]
// ---------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and codes of the i2c register transaction sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cseq_pkg;

   // input beat kinds
   localparam logic [1:0] KIND_REQ  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // engine completion codes
   localparam logic [1:0] ES_OK      = 2'd0;
   localparam logic [1:0] ES_TIMEOUT = 2'd1;

   // byte engine commands
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_SEND   = 3'd2;
   localparam logic [2:0] CMD_RSTART = 3'd3;
   localparam logic [2:0] CMD_RXACK  = 3'd4;
   localparam logic [2:0] CMD_RXNACK = 3'd5;
   localparam logic [2:0] CMD_STOP   = 3'd6;

   // transaction status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_ARB_LOST  = 3'd2;
   localparam logic [2:0] ST_ADDR_NACK = 3'd3;
   localparam logic [2:0] ST_DATA_NACK = 3'd4;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_START  = 7'b0000010,
      PH_REGB   = 7'b0000100,
      PH_WAITD  = 7'b0001000,
      PH_SENDD  = 7'b0010000,
      PH_RSTART = 7'b0100000,
      PH_RECV   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        is_read;
      logic [6:0]  dev_addr;
      logic [7:0]  reg_addr;
      logic [15:0] transfer_length;
      logic [7:0]  write_byte;
      logic [1:0]  engine_status;
      logic        ack_missing;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] command_byte;
      logic [7:0] read_data;
      logic       read_valid;
      logic       need_write_byte;
      logic       done_res;
      logic [2:0] status;
   } result_type;

   function automatic logic [2:0] err_code(input logic [1:0] es);
      err_code = (es == ES_TIMEOUT) ? ST_TIMEOUT : ST_ARB_LOST;
   endfunction

endpackage

`default_nettype wire

[design/i2cseq_fsm.sv]
// ---------------------------------------------------------------------------
// i2cseq_fsm
// Transaction phase machine: takes one event per cycle while fire is high,
// updates the transaction state and forms the result beat, if any.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_fsm (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     fire,
   input  i2cseq_pkg::item_type    item,
   output logic                    has_result,
   output i2cseq_pkg::result_type  result
);

   i2cseq_pkg::phase_type phase_ff, phase_in;
   logic        dir_read_ff, dir_read_in;
   logic [6:0]  target_ff, target_in;
   logic [7:0]  regb_ff, regb_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] left_m1;
   logic        es_err;

   assign left_m1 = left_ff - 16'd1;
   assign es_err  = (item.engine_status != i2cseq_pkg::ES_OK);

   always_comb begin
      phase_in    = phase_ff;
      dir_read_in = dir_read_ff;
      target_in   = target_ff;
      regb_in     = regb_ff;
      left_in     = left_ff;
      has_result  = 1'b0;
      result      = '0;
      case (item.kind)
         i2cseq_pkg::KIND_REQ: begin
            if (phase_ff == i2cseq_pkg::PH_IDLE) begin
               dir_read_in         = item.is_read;
               target_in           = item.dev_addr;
               regb_in             = item.reg_addr;
               left_in             = item.transfer_length;
               phase_in            = i2cseq_pkg::PH_START;
               has_result          = 1'b1;
               result.bus_command  = i2cseq_pkg::CMD_START;
               result.command_byte = {item.dev_addr, 1'b0};
            end
         end
         i2cseq_pkg::KIND_DATA: begin
            if (phase_ff == i2cseq_pkg::PH_WAITD) begin
               phase_in            = i2cseq_pkg::PH_SENDD;
               has_result          = 1'b1;
               result.bus_command  = i2cseq_pkg::CMD_SEND;
               result.command_byte = item.write_byte;
            end
         end
         i2cseq_pkg::KIND_DONE: begin
            has_result = 1'b1;
            case (phase_ff)
               i2cseq_pkg::PH_START: begin
                  if (es_err) begin
                     // failed first start: no stop
                     phase_in        = i2cseq_pkg::PH_IDLE;
                     result.done_res = 1'b1;
                     result.status   = i2cseq_pkg::err_code(item.engine_status);
                  end else if (item.ack_missing) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                     result.status      = i2cseq_pkg::ST_ADDR_NACK;
                  end else begin
                     phase_in            = i2cseq_pkg::PH_REGB;
                     result.bus_command  = i2cseq_pkg::CMD_SEND;
                     result.command_byte = regb_ff;
                  end
               end
               i2cseq_pkg::PH_REGB: begin
                  if (es_err || item.ack_missing) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                     result.status      = es_err ?
                        i2cseq_pkg::err_code(item.engine_status) :
                        i2cseq_pkg::ST_DATA_NACK;
                  end else if (dir_read_ff) begin
                     phase_in            = i2cseq_pkg::PH_RSTART;
                     result.bus_command  = i2cseq_pkg::CMD_RSTART;
                     result.command_byte = {target_ff, 1'b1};
                  end else if (left_ff == 16'd0) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                  end else begin
                     phase_in               = i2cseq_pkg::PH_WAITD;
                     result.need_write_byte = 1'b1;
                  end
               end
               i2cseq_pkg::PH_SENDD: begin
                  if (es_err || item.ack_missing) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                     result.status      = es_err ?
                        i2cseq_pkg::err_code(item.engine_status) :
                        i2cseq_pkg::ST_DATA_NACK;
                  end else begin
                     left_in = left_m1;
                     if (left_m1 == 16'd0) begin
                        phase_in           = i2cseq_pkg::PH_IDLE;
                        result.bus_command = i2cseq_pkg::CMD_STOP;
                        result.done_res    = 1'b1;
                     end else begin
                        phase_in               = i2cseq_pkg::PH_WAITD;
                        result.need_write_byte = 1'b1;
                     end
                  end
               end
               i2cseq_pkg::PH_RSTART: begin
                  if (es_err || item.ack_missing) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                     result.status      = es_err ?
                        i2cseq_pkg::err_code(item.engine_status) :
                        i2cseq_pkg::ST_ADDR_NACK;
                  end else if (left_ff == 16'd0) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                  end else begin
                     phase_in           = i2cseq_pkg::PH_RECV;
                     result.bus_command = (left_ff == 16'd1) ?
                        i2cseq_pkg::CMD_RXNACK : i2cseq_pkg::CMD_RXACK;
                  end
               end
               i2cseq_pkg::PH_RECV: begin
                  // ack_missing means nothing on receives
                  if (es_err) begin
                     phase_in           = i2cseq_pkg::PH_IDLE;
                     result.bus_command = i2cseq_pkg::CMD_STOP;
                     result.done_res    = 1'b1;
                     result.status      = i2cseq_pkg::err_code(item.engine_status);
                  end else begin
                     left_in           = left_m1;
                     result.read_data  = item.rx_byte;
                     result.read_valid = 1'b1;
                     if (left_m1 == 16'd0) begin
                        phase_in           = i2cseq_pkg::PH_IDLE;
                        result.bus_command = i2cseq_pkg::CMD_STOP;
                        result.done_res    = 1'b1;
                     end else begin
                        result.bus_command = (left_m1 == 16'd1) ?
                           i2cseq_pkg::CMD_RXNACK : i2cseq_pkg::CMD_RXACK;
                     end
                  end
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= i2cseq_pkg::PH_IDLE;
         dir_read_ff <= 1'b0;
         target_ff   <= '0;
         regb_ff     <= '0;
         left_ff     <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         dir_read_ff <= dir_read_in;
         target_ff   <= target_in;
         regb_ff     <= regb_in;
         left_ff     <= left_in;
      end
   end

endmodule

`default_nettype wire

[design/i2c_register_transaction_sequencer_unit.sv]
// ---------------------------------------------------------------------------
// i2c_register_transaction_sequencer_unit
// Byte-level I2C master sequencer for one register read or write transaction.
// ---------------------------------------------------------------------------
// Takes one event beat per cycle unless req_stall is high: a request, a
// write data byte or a byte engine completion. Each beat is latched in an
// input register, handled by the phase machine once the result register is
// free or draining, and its result (if any) is held in the result register;
// the block sustains one beat per clock while the result side keeps up.
// Beats that make no sense in the current phase produce no result.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transaction_sequencer_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [1:0]   req_kind,
   input  wire          req_is_read,
   input  wire  [6:0]   req_dev_addr,
   input  wire  [7:0]   req_reg_addr,
   input  wire  [15:0]  req_transfer_length,
   input  wire  [7:0]   req_write_byte,
   input  wire  [1:0]   req_engine_status,
   input  wire          req_ack_missing,
   input  wire  [7:0]   req_rx_byte,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [2:0]   rsp_bus_command,
   output logic [7:0]   rsp_command_byte,
   output logic [7:0]   rsp_read_data,
   output logic         rsp_read_valid,
   output logic         rsp_need_write_byte,
   output logic         rsp_done_res,
   output logic [2:0]   rsp_status
);

   logic                   in_valid_ff, in_valid_in;
   i2cseq_pkg::item_type   in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   i2cseq_pkg::result_type out_res_ff;
   logic                   fire;
   logic                   accept;
   logic                   has_result;
   i2cseq_pkg::result_type result;

   // process the held beat when the result slot is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = has_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= '{kind:            req_kind,
                         is_read:         req_is_read,
                         dev_addr:        req_dev_addr,
                         reg_addr:        req_reg_addr,
                         transfer_length: req_transfer_length,
                         write_byte:      req_write_byte,
                         engine_status:   req_engine_status,
                         ack_missing:     req_ack_missing,
                         rx_byte:         req_rx_byte};
      end
      if (fire && has_result) begin
         out_res_ff <= result;
      end
   end

   i2cseq_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_bus_command     = out_res_ff.bus_command;
   assign rsp_command_byte    = out_res_ff.command_byte;
   assign rsp_read_data       = out_res_ff.read_data;
   assign rsp_read_valid      = out_res_ff.read_valid;
   assign rsp_need_write_byte = out_res_ff.need_write_byte;
   assign rsp_done_res        = out_res_ff.done_res;
   assign rsp_status          = out_res_ff.status;

endmodule

`default_nettype wire

[design/i2cseq_checker.sv]
// ---------------------------------------------------------------------------
// i2cseq_checker
// Port-level checks of the sequencer's result beats, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cseq_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [2:0]  rsp_bus_command,
   input wire        rsp_read_valid,
   input wire        rsp_need_write_byte,
   input wire        rsp_done_res,
   input wire [2:0]  rsp_status
);

   // a stalled beat stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == i2cseq_pkg::ST_OK)
      else $error("status set on unfinished beat");

   a_read_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |->
         rsp_bus_command == i2cseq_pkg::CMD_RXACK ||
         rsp_bus_command == i2cseq_pkg::CMD_RXNACK ||
         rsp_bus_command == i2cseq_pkg::CMD_STOP)
      else $error("received byte with wrong command");

   a_need_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_need_write_byte |->
         rsp_bus_command == i2cseq_pkg::CMD_NONE && !rsp_done_res)
      else $error("data request mixed with command");

   a_addr_nack_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status == i2cseq_pkg::ST_ADDR_NACK |->
         rsp_bus_command == i2cseq_pkg::CMD_STOP)
      else $error("address nack without stop");

endmodule

bind i2c_register_transaction_sequencer_unit i2cseq_checker u_i2cseq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_bus_command     (rsp_bus_command),
   .rsp_read_valid      (rsp_read_valid),
   .rsp_need_write_byte (rsp_need_write_byte),
   .rsp_done_res        (rsp_done_res),
   .rsp_status          (rsp_status)
);

`default_nettype wire

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the i2c register transaction sequencer.
// ---------------------------------------------------------------------------
// The bench plays both the requester and the byte engine. Each event beat is
// chosen from the bench's own copy of the sequencer state, so most traffic
// follows legal transactions while some stray beats probe the ignore paths.
// Every accepted beat runs through the bench's sequencer model. The model
// queues the bus action it predicts, and a monitor compares each result beat
// field by field. Both channels see random gaps, and one long result-side
// hold fills the block until it stalls its input.
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_BEATS = 458;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] ES_ARB_LOST = 2'd2;
   localparam logic [1:0] ES_RESERVED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_stall;
   logic [1:0]  req_kind = i2cseq_pkg::KIND_REQ;
   logic        req_is_read = 1'b0;
   logic [6:0]  req_dev_addr = '0;
   logic [7:0]  req_reg_addr = '0;
   logic [15:0] req_transfer_length = '0;
   logic [7:0]  req_write_byte = '0;
   logic [1:0]  req_engine_status = i2cseq_pkg::ES_OK;
   logic        req_ack_missing = 1'b0;
   logic [7:0]  req_rx_byte = '0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire [2:0]   rsp_bus_command;
   wire [7:0]   rsp_command_byte;
   wire [7:0]   rsp_read_data;
   wire         rsp_read_valid;
   wire         rsp_need_write_byte;
   wire         rsp_done_res;
   wire [2:0]   rsp_status;

   i2c_register_transaction_sequencer_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_is_read         (req_is_read),
      .req_dev_addr        (req_dev_addr),
      .req_reg_addr        (req_reg_addr),
      .req_transfer_length (req_transfer_length),
      .req_write_byte      (req_write_byte),
      .req_engine_status   (req_engine_status),
      .req_ack_missing     (req_ack_missing),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_bus_command     (rsp_bus_command),
      .rsp_command_byte    (rsp_command_byte),
      .rsp_read_data       (rsp_read_data),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_need_write_byte (rsp_need_write_byte),
      .rsp_done_res        (rsp_done_res),
      .rsp_status          (rsp_status)
   );

   // bench copy of the sequencer state
   i2cseq_pkg::phase_type seq_phase = i2cseq_pkg::PH_IDLE;
   logic        seq_is_read = 1'b0;
   logic [6:0]  seq_target = '0;
   logic [7:0]  seq_register = '0;
   logic [15:0] seq_remaining = '0;

   i2cseq_pkg::result_type expected_actions[$];
   i2cseq_pkg::result_type head_action;
   int          error_count = 0;
   int          cycle_count;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_armed = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic logic [2:0] fault_status(input logic [1:0] es);
      fault_status = (es == i2cseq_pkg::ES_TIMEOUT) ? i2cseq_pkg::ST_TIMEOUT :
                                                      i2cseq_pkg::ST_ARB_LOST;
   endfunction

   function automatic i2cseq_pkg::result_type stop_action(input logic [2:0] st,
                                                          input logic [7:0] rdata,
                                                          input logic rvalid);
      i2cseq_pkg::result_type r;
      r = '0;
      seq_phase = i2cseq_pkg::PH_IDLE;
      r.bus_command = i2cseq_pkg::CMD_STOP;
      r.read_data = rdata;
      r.read_valid = rvalid;
      r.done_res = 1'b1;
      r.status = st;
      stop_action = r;
   endfunction

   function automatic i2cseq_pkg::result_type receive_action(input logic [7:0] rdata,
                                                             input logic rvalid);
      i2cseq_pkg::result_type r;
      r = '0;
      seq_phase = i2cseq_pkg::PH_RECV;
      r.bus_command = (seq_remaining == 16'd1) ? i2cseq_pkg::CMD_RXNACK :
                                                 i2cseq_pkg::CMD_RXACK;
      r.read_data = rdata;
      r.read_valid = rvalid;
      receive_action = r;
   endfunction

   function automatic i2cseq_pkg::result_type wait_data_action();
      i2cseq_pkg::result_type r;
      r = '0;
      seq_phase = i2cseq_pkg::PH_WAITD;
      r.need_write_byte = 1'b1;
      wait_data_action = r;
   endfunction

   // advances the model by one beat; returns 1 when the beat makes a result
   function automatic bit sequence_step(input i2cseq_pkg::item_type ev,
                                        output i2cseq_pkg::result_type r);
      bit gives;
      gives = 1'b1;
      r = '0;
      if (ev.kind == i2cseq_pkg::KIND_REQ) begin
         if (seq_phase != i2cseq_pkg::PH_IDLE) begin
            gives = 1'b0;
         end else begin
            seq_is_read = ev.is_read;
            seq_target = ev.dev_addr;
            seq_register = ev.reg_addr;
            seq_remaining = ev.transfer_length;
            seq_phase = i2cseq_pkg::PH_START;
            r.bus_command = i2cseq_pkg::CMD_START;
            r.command_byte = {ev.dev_addr, 1'b0};
         end
      end else if (ev.kind == i2cseq_pkg::KIND_DATA) begin
         if (seq_phase != i2cseq_pkg::PH_WAITD) begin
            gives = 1'b0;
         end else begin
            seq_phase = i2cseq_pkg::PH_SENDD;
            r.bus_command = i2cseq_pkg::CMD_SEND;
            r.command_byte = ev.write_byte;
         end
      end else if (ev.kind != i2cseq_pkg::KIND_DONE) begin
         gives = 1'b0;
      end else begin
         case (seq_phase)
            i2cseq_pkg::PH_START: begin
               if (ev.engine_status != i2cseq_pkg::ES_OK) begin
                  // failed first start ends without a stop
                  seq_phase = i2cseq_pkg::PH_IDLE;
                  r.done_res = 1'b1;
                  r.status = fault_status(ev.engine_status);
               end else if (ev.ack_missing) begin
                  r = stop_action(i2cseq_pkg::ST_ADDR_NACK, 8'h00, 1'b0);
               end else begin
                  seq_phase = i2cseq_pkg::PH_REGB;
                  r.bus_command = i2cseq_pkg::CMD_SEND;
                  r.command_byte = seq_register;
               end
            end
            i2cseq_pkg::PH_REGB: begin
               if (ev.engine_status != i2cseq_pkg::ES_OK) begin
                  r = stop_action(fault_status(ev.engine_status), 8'h00, 1'b0);
               end else if (ev.ack_missing) begin
                  r = stop_action(i2cseq_pkg::ST_DATA_NACK, 8'h00, 1'b0);
               end else if (seq_is_read) begin
                  seq_phase = i2cseq_pkg::PH_RSTART;
                  r.bus_command = i2cseq_pkg::CMD_RSTART;
                  r.command_byte = {seq_target, 1'b1};
               end else if (seq_remaining == 16'd0) begin
                  r = stop_action(i2cseq_pkg::ST_OK, 8'h00, 1'b0);
               end else begin
                  r = wait_data_action();
               end
            end
            i2cseq_pkg::PH_SENDD: begin
               if (ev.engine_status != i2cseq_pkg::ES_OK) begin
                  r = stop_action(fault_status(ev.engine_status), 8'h00, 1'b0);
               end else if (ev.ack_missing) begin
                  r = stop_action(i2cseq_pkg::ST_DATA_NACK, 8'h00, 1'b0);
               end else begin
                  seq_remaining = seq_remaining - 16'd1;
                  if (seq_remaining == 16'd0) begin
                     r = stop_action(i2cseq_pkg::ST_OK, 8'h00, 1'b0);
                  end else begin
                     r = wait_data_action();
                  end
               end
            end
            i2cseq_pkg::PH_RSTART: begin
               if (ev.engine_status != i2cseq_pkg::ES_OK) begin
                  r = stop_action(fault_status(ev.engine_status), 8'h00, 1'b0);
               end else if (ev.ack_missing) begin
                  r = stop_action(i2cseq_pkg::ST_ADDR_NACK, 8'h00, 1'b0);
               end else if (seq_remaining == 16'd0) begin
                  r = stop_action(i2cseq_pkg::ST_OK, 8'h00, 1'b0);
               end else begin
                  r = receive_action(8'h00, 1'b0);
               end
            end
            i2cseq_pkg::PH_RECV: begin
               // ack_missing means nothing on a receive
               if (ev.engine_status != i2cseq_pkg::ES_OK) begin
                  r = stop_action(fault_status(ev.engine_status), 8'h00, 1'b0);
               end else begin
                  seq_remaining = seq_remaining - 16'd1;
                  if (seq_remaining == 16'd0) begin
                     r = stop_action(i2cseq_pkg::ST_OK, ev.rx_byte, 1'b1);
                  end else begin
                     r = receive_action(ev.rx_byte, 1'b1);
                  end
               end
            end
            default: begin
               gives = 1'b0;
            end
         endcase
      end
      sequence_step = gives;
   endfunction

   // ------------------------------------------------------------------------
   // event beats
   // ------------------------------------------------------------------------
   function automatic i2cseq_pkg::item_type blank_event();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      blank_event = bits[$bits(i2cseq_pkg::item_type)-1:0];
   endfunction

   function automatic i2cseq_pkg::item_type ev_req(input logic rd, input logic [6:0] addr,
                                                   input logic [7:0] regb,
                                                   input logic [15:0] len);
      i2cseq_pkg::item_type ev;
      ev = blank_event();
      ev.kind = i2cseq_pkg::KIND_REQ;
      ev.is_read = rd;
      ev.dev_addr = addr;
      ev.reg_addr = regb;
      ev.transfer_length = len;
      ev_req = ev;
   endfunction

   function automatic i2cseq_pkg::item_type ev_done(input logic [1:0] es, input logic nack,
                                                    input logic [7:0] rx);
      i2cseq_pkg::item_type ev;
      ev = blank_event();
      ev.kind = i2cseq_pkg::KIND_DONE;
      ev.engine_status = es;
      ev.ack_missing = nack;
      ev.rx_byte = rx;
      ev_done = ev;
   endfunction

   function automatic i2cseq_pkg::item_type ev_kind(input logic [1:0] kind);
      i2cseq_pkg::item_type ev;
      ev = blank_event();
      ev.kind = kind;
      ev_kind = ev;
   endfunction

   // mostly the beat the sequencer waits for, now and then a stray one
   function automatic i2cseq_pkg::item_type next_event();
      i2cseq_pkg::item_type ev;
      logic [1:0] awaited;
      int fault_pct;
      ev = blank_event();
      awaited = (seq_phase == i2cseq_pkg::PH_IDLE) ? i2cseq_pkg::KIND_REQ :
                (seq_phase == i2cseq_pkg::PH_WAITD) ? i2cseq_pkg::KIND_DATA :
                i2cseq_pkg::KIND_DONE;
      if ($urandom_range(99) < 91) begin
         ev.kind = awaited;
         if (awaited == i2cseq_pkg::KIND_REQ && $urandom_range(99) < 85)
            ev.transfer_length = 16'($urandom_range(5));
         if (awaited == i2cseq_pkg::KIND_DONE) begin
            // long transfers get cut short by errors
            fault_pct = (seq_remaining > 16'd16) ? 20 : 5;
            ev.engine_status = ($urandom_range(99) < fault_pct) ?
                               2'($urandom_range(3, 1)) : i2cseq_pkg::ES_OK;
            ev.ack_missing = ($urandom_range(99) < 5);
         end
      end else begin
         do ev.kind = 2'($urandom_range(3)); while (ev.kind == awaited);
      end
      next_event = ev;
   endfunction

   // one beat on the request channel, entered and left at a falling edge
   task automatic drive_event(input i2cseq_pkg::item_type ev);
      i2cseq_pkg::result_type act;
      bit gives;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_kind = ev.kind;
      req_is_read = ev.is_read;
      req_dev_addr = ev.dev_addr;
      req_reg_addr = ev.reg_addr;
      req_transfer_length = ev.transfer_length;
      req_write_byte = ev.write_byte;
      req_engine_status = ev.engine_status;
      req_ack_missing = ev.ack_missing;
      req_rx_byte = ev.rx_byte;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gives = sequence_step(ev, act);
      if (gives) begin
         expected_actions.push_back(act);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_actions.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int wanted, input int seen);
      if (wanted != seen) begin
         $display("%0t: %s expected %0d got %0d", $time, name, wanted, seen);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none got command %0d",
                     $time, rsp_bus_command);
            error_count++;
         end else begin
            head_action = expected_actions.pop_front();
            check_field("bus_command", int'(head_action.bus_command),
                        int'(rsp_bus_command));
            check_field("command_byte", int'(head_action.command_byte),
                        int'(rsp_command_byte));
            check_field("read_data", int'(head_action.read_data), int'(rsp_read_data));
            check_field("read_valid", int'(head_action.read_valid), int'(rsp_read_valid));
            check_field("need_write_byte", int'(head_action.need_write_byte),
                        int'(rsp_need_write_byte));
            check_field("done_res", int'(head_action.done_res), int'(rsp_done_res));
            check_field("status", int'(head_action.status), int'(rsp_status));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_ignored_in_idle();
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h5a));
      drive_event(ev_kind(i2cseq_pkg::KIND_DATA));
      drive_event(ev_kind(KIND_UNUSED));
   endtask

   task automatic test_write_paths();
      // zero length stops right after the register byte
      drive_event(ev_req(1'b0, 7'h7f, 8'hff, 16'd0));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_req(1'b0, 7'h55, 8'h2a, 16'd1));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_kind(i2cseq_pkg::KIND_DATA));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
   endtask

   task automatic test_read_paths();
      i2cseq_pkg::item_type ev;
      drive_event(ev_req(1'b1, 7'h00, 8'h00, 16'd2));
      drive_event(ev_kind(i2cseq_pkg::KIND_REQ));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      ev = ev_kind(i2cseq_pkg::KIND_DATA);
      ev.write_byte = 8'hff;
      drive_event(ev);
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b1, 8'hff));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      // address nack on the repeated start
      drive_event(ev_req(1'b1, 7'h2a, 8'h55, 16'hffff));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b1, 8'h00));
   endtask

   task automatic test_error_paths();
      drive_event(ev_req(1'b0, 7'h11, 8'h80, 16'hffff));
      drive_event(ev_done(i2cseq_pkg::ES_TIMEOUT, 1'b1, 8'h00));
      drive_event(ev_req(1'b1, 7'h40, 8'h01, 16'h8000));
      drive_event(ev_done(ES_RESERVED, 1'b0, 8'h00));
      drive_event(ev_req(1'b0, 7'h01, 8'h7f, 16'd4));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b1, 8'h00));
      // nack on the register byte
      drive_event(ev_req(1'b0, 7'h3c, 8'hc3, 16'd3));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b1, 8'h00));
      drive_event(ev_req(1'b1, 7'h62, 8'h10, 16'd1));
      drive_event(ev_done(i2cseq_pkg::ES_OK, 1'b0, 8'h00));
      drive_event(ev_done(ES_ARB_LOST, 1'b0, 8'h00));
   endtask

   task automatic test_random_traffic(input int send_idle, input int recv_idle, input int count);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      repeat (count) drive_event(next_event());
      wait_drained();
   endtask

   task automatic test_result_hold();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed = 1'b1;
      repeat (40) drive_event(next_event());
      wait_drained();
   endtask

   initial begin
      for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 61;
      test_ignored_in_idle();
      test_write_paths();
      test_read_paths();
      test_error_paths();
      wait_drained();
      test_random_traffic(30, 61, RANDOM_BEATS);
      test_random_traffic(61, 30, RANDOM_BEATS);
      test_result_hold();
      test_random_traffic(0, 0, RANDOM_BEATS);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
design/i2cseq_pkg.sv
design/i2cseq_fsm.sv
design/i2c_register_transaction_sequencer_unit.sv
design/i2cseq_checker.sv
tb/sv/tb.sv
